// File: hw/rtl/nns_pkg.sv
`default_nettype none
package nns_pkg;

  // fixed field widths
  localparam int unsigned FUNC_W     = 1;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 4 * CH_W;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned SZ_W       = 9;
  localparam int unsigned STEP_W     = 25;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = STEP_W;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_STORE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FETCH = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP        = 3'd6;

  // channel counts
  localparam logic [CNT_W-1:0] CH_RGB  = 3'd3;
  localparam logic [CNT_W-1:0] CH_RGBA = 3'd4;

  // register reset values
  localparam logic [SZ_W-1:0]   SIZE_RST = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RST = 25'd65536;

endpackage
`default_nettype wire

// File: hw/rtl/nns_if.sv
`default_nettype none
interface nns_in_if import nns_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic                frame_start;
  logic [COORD_W-1:0]  dst_x;
  logic [COORD_W-1:0]  dst_y;
  logic [CH_W-1:0]     in_ch0;
  logic [CH_W-1:0]     in_ch1;
  logic [CH_W-1:0]     in_ch2;
  logic [CH_W-1:0]     in_ch3;

  modport source (
    output valid, func, frame_start, dst_x, dst_y, in_ch0, in_ch1, in_ch2, in_ch3,
    input  ready
  );
  modport sink (
    input  valid, func, frame_start, dst_x, dst_y, in_ch0, in_ch1, in_ch2, in_ch3,
    output ready
  );
endinterface

interface nns_out_if import nns_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_ch0;
  logic [CH_W-1:0] out_ch1;
  logic [CH_W-1:0] out_ch2;
  logic [CH_W-1:0] out_ch3;
  logic            range_error;

  modport source (
    output valid, out_ch0, out_ch1, out_ch2, out_ch3, range_error,
    input  ready
  );
  modport sink (
    input  valid, out_ch0, out_ch1, out_ch2, out_ch3, range_error,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/nns_frame_mem.sv
`default_nettype none
module nns_frame_mem import nns_pkg::*; #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [PIX_W-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/nearest_neighbor_image_scaler.sv
// a fetch result passes stages 1 to 3 and the frame store read register
// throughput: one item per cycle unless stalled, set by the single write and single
//   read port of the frame store; a store and a fetch take the same pipeline slot in order
// a held result stalls the input only once all three stages are full and stage 3 holds a fetch
// reset: pointer, pipeline and registers cleared to defaults; frame store
//   contents are not cleared and read as undefined until written
`default_nettype none
module nearest_neighbor_image_scaler import nns_pkg::*; #(
  parameter int unsigned MAX_DIM    = 256,
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  nns_in_if.sink                     in_chan,
  nns_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PTR_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PX_W   = COORD_W + STEP_W;
  localparam int unsigned PRD_W  = 2 * SZ_W;
  localparam int unsigned SUM_W  = PRD_W + 1;

  // configuration
  logic [CNT_W-1:0]  cc_r;
  logic [SZ_W-1:0]   src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [STEP_W-1:0] x_step_r, y_step_r;

  // clamped source size and store bound
  logic [SZ_W-1:0]  sw, sh;
  logic [PRD_W-1:0] area;
  logic [PTR_W-1:0] store_bound;

  // write pointer
  logic [PTR_W-1:0] ptr_r, ptr_nxt, ptr_use;
  logic             store_ok;

  // handshake
  logic acc, is_fetch, fetch_err;
  logic s1_free, s2_free, s3_free;

  // stage 1: products
  logic              s1_v_r, s1_fetch_r, s1_err_r;
  logic [PX_W-1:0]   s1_px_r, s1_py_r;
  logic [ADDR_W-1:0] s1_waddr_r;
  logic [PIX_W-1:0]  s1_wdata_r;
  // stage 2: source column and row
  logic              s2_v_r, s2_fetch_r, s2_err_r;
  logic [SZ_W-1:0]   s2_sx_r, s2_sy_r;
  logic [ADDR_W-1:0] s2_waddr_r;
  logic [PIX_W-1:0]  s2_wdata_r;
  // stage 3: row offset, memory access
  logic              s3_v_r, s3_fetch_r, s3_err_r;
  logic [PRD_W-1:0]  s3_row_r;
  logic [SZ_W-1:0]   s3_sx_r;
  logic [ADDR_W-1:0] s3_waddr_r;
  logic [PIX_W-1:0]  s3_wdata_r;
  // result
  logic              out_v_r, out_err_r;

  logic [PX_W-1:0]   sx_full, sy_full;
  logic [SZ_W-1:0]   sx_c, sy_c;
  logic [SUM_W-1:0]  addr_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we, mem_re;
  logic [PIX_W-1:0]  rd_data;

  always_comb begin
    sw = src_w_r;
    if (src_w_r == '0) begin
      sw = SZ_W'(1);
    end else if (32'(src_w_r) > 32'(MAX_DIM)) begin
      sw = SZ_W'(MAX_DIM);
    end
    sh = src_h_r;
    if (src_h_r == '0) begin
      sh = SZ_W'(1);
    end else if (32'(src_h_r) > 32'(MAX_DIM)) begin
      sh = SZ_W'(MAX_DIM);
    end
    area = PRD_W'(sw) * PRD_W'(sh);
    store_bound = (32'(area) > 32'(MAX_PIXELS)) ? PTR_W'(MAX_PIXELS) : PTR_W'(area);
  end

  assign s3_free = !s3_v_r || !s3_fetch_r || !out_v_r || out_chan.ready;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_free = !s1_v_r || s2_free;
  assign in_chan.ready = s1_free;
  assign acc = in_chan.valid && s1_free;
  assign is_fetch = (in_chan.func == FUNC_FETCH);
  assign fetch_err = ({1'b0, in_chan.dst_x} >= dst_w_r) || ({1'b0, in_chan.dst_y} >= dst_h_r);

  always_comb begin
    ptr_use  = in_chan.frame_start ? '0 : ptr_r;
    store_ok = (ptr_use < store_bound);
    ptr_nxt  = ptr_r;
    if (acc && !is_fetch) begin
      ptr_nxt = store_ok ? PTR_W'(ptr_use + 1'b1) : ptr_use;
    end
  end

  // saturate scaled coordinates to the last column and row
  always_comb begin
    sx_full = s1_px_r >> FRAC_BITS;
    sy_full = s1_py_r >> FRAC_BITS;
    sx_c = (sx_full >= PX_W'(sw)) ? SZ_W'(sw - 1'b1) : sx_full[SZ_W-1:0];
    sy_c = (sy_full >= PX_W'(sh)) ? SZ_W'(sh - 1'b1) : sy_full[SZ_W-1:0];
  end

  always_comb begin
    addr_sum = SUM_W'(s3_row_r) + SUM_W'(s3_sx_r);
    rd_addr  = (32'(addr_sum) >= 32'(MAX_PIXELS)) ? ADDR_W'(MAX_PIXELS - 1)
                                                   : ADDR_W'(addr_sum);
  end

  assign mem_we = s3_v_r && !s3_fetch_r;
  assign mem_re = s3_v_r && s3_fetch_r && s3_free;

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r     <= CH_RGB;
      src_w_r  <= SIZE_RST;
      src_h_r  <= SIZE_RST;
      dst_w_r  <= SIZE_RST;
      dst_h_r  <= SIZE_RST;
      x_step_r <= STEP_RST;
      y_step_r <= STEP_RST;
      ptr_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_CHANNEL_COUNT: cc_r     <= cfg_wdata[CNT_W-1:0];
          REG_SRC_WIDTH:     src_w_r  <= cfg_wdata[SZ_W-1:0];
          REG_SRC_HEIGHT:    src_h_r  <= cfg_wdata[SZ_W-1:0];
          REG_DST_WIDTH:     dst_w_r  <= cfg_wdata[SZ_W-1:0];
          REG_DST_HEIGHT:    dst_h_r  <= cfg_wdata[SZ_W-1:0];
          REG_X_STEP:        x_step_r <= cfg_wdata[STEP_W-1:0];
          REG_Y_STEP:        y_step_r <= cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      ptr_r <= ptr_nxt;
      // dropped stores do not enter the pipeline
      if (s1_free) begin
        s1_v_r <= acc && (is_fetch || store_ok);
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (out_v_r && out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      if (mem_re) begin
        out_v_r <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_fetch_r <= is_fetch;
      s1_err_r   <= fetch_err;
      s1_px_r    <= PX_W'(in_chan.dst_x) * PX_W'(x_step_r);
      s1_py_r    <= PX_W'(in_chan.dst_y) * PX_W'(y_step_r);
      s1_waddr_r <= ADDR_W'(ptr_use);
      s1_wdata_r <= {in_chan.in_ch3, in_chan.in_ch2, in_chan.in_ch1, in_chan.in_ch0};
    end
    if (s2_free) begin
      s2_fetch_r <= s1_fetch_r;
      s2_err_r   <= s1_err_r;
      s2_sx_r    <= sx_c;
      s2_sy_r    <= sy_c;
      s2_waddr_r <= s1_waddr_r;
      s2_wdata_r <= s1_wdata_r;
    end
    if (s3_free) begin
      s3_fetch_r <= s2_fetch_r;
      s3_err_r   <= s2_err_r;
      s3_row_r   <= PRD_W'(s2_sy_r) * PRD_W'(sw);
      s3_sx_r    <= s2_sx_r;
      s3_waddr_r <= s2_waddr_r;
      s3_wdata_r <= s2_wdata_r;
    end
    if (mem_re) begin
      out_err_r <= s3_err_r;
    end
  end

  nns_frame_mem #(
    .DEPTH  (MAX_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s3_waddr_r),
    .wdata (s3_wdata_r),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_chan.valid       = out_v_r;
  assign out_chan.range_error = out_err_r;
  assign out_chan.out_ch0     = out_err_r ? '0 : rd_data[CH_W-1:0];
  assign out_chan.out_ch1     = out_err_r ? '0 : rd_data[2*CH_W-1:CH_W];
  assign out_chan.out_ch2     = out_err_r ? '0 : rd_data[3*CH_W-1:2*CH_W];
  assign out_chan.out_ch3     = (out_err_r || (cc_r != CH_RGBA)) ? '0
                                                                 : rd_data[4*CH_W-1:3*CH_W];

`ifndef SYNTH
  a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(MAX_PIXELS))
    else $error("write pointer beyond frame store");

  a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !is_fetch && !in_chan.frame_start && (ptr_r < store_bound))
      |=> (ptr_r == PTR_W'($past(ptr_r) + 1'b1)))
    else $error("accepted store did not advance the write pointer");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s3_v_r && s3_fetch_r))
    else $error("result raised without a fetch in the memory stage");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_v_r && s2_v_r && s3_v_r && out_v_r))
    else $error("input stalled with a free pipeline slot");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  import nns_pkg::*;

  localparam int unsigned FRAME_WORDS  = 65536;
  localparam int unsigned FRAC         = 16;
  localparam int unsigned DIM_MAX      = 256;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned TARGET_ITEMS = 1050;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic                 frame_start;
    logic [COORD_W-1:0]   dst_x;
    logic [COORD_W-1:0]   dst_y;
    logic [3:0][CH_W-1:0] ch;
  } px_item_t;

  typedef struct packed {
    logic [3:0][CH_W-1:0] ch;
    logic                 range_error;
  } px_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nns_in_if  in_if ();
  nns_out_if out_if ();

  nearest_neighbor_image_scaler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // own copy of the scaler state and registers
  logic [CNT_W-1:0]  m_channels;
  logic [SZ_W-1:0]   m_src_w, m_src_h, m_dst_w, m_dst_h;
  logic [STEP_W-1:0] m_x_step, m_y_step;
  int unsigned       wr_ptr;
  logic [PIX_W-1:0]  frame_px [FRAME_WORDS];
  bit                px_written [FRAME_WORDS];
  px_result_t        expected_px [$];

  int unsigned n_items, n_stores, n_fetches, n_range_err, n_results, n_errors, n_settings;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          src_idle = 1'b1;
  bit          snk_idle = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("nearest_neighbor_image_scaler test failed");
      $finish;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  function automatic int unsigned clamp_dim(input logic [SZ_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic int unsigned frame_bound();
    longint unsigned n;
    n = clamp_dim(m_src_w);
    n = n * clamp_dim(m_src_h);
    if (n > FRAME_WORDS) n = FRAME_WORDS;
    return n;
  endfunction

  function automatic int unsigned scale_coord(input logic [COORD_W-1:0] d,
                                              input logic [STEP_W-1:0] step,
                                              input int unsigned lim);
    longint unsigned s;
    s = d;
    s = (s * step) >> FRAC;
    if (s >= lim) s = lim - 1;
    return s;
  endfunction

  function automatic int unsigned source_addr(input logic [COORD_W-1:0] dx,
                                              input logic [COORD_W-1:0] dy);
    int unsigned     sw;
    longint unsigned a;
    sw = clamp_dim(m_src_w);
    a  = scale_coord(dy, m_y_step, clamp_dim(m_src_h));
    a  = a * sw + scale_coord(dx, m_x_step, sw);
    if (a >= FRAME_WORDS) a = FRAME_WORDS - 1;
    return a;
  endfunction

  function automatic bit outside_dst(input logic [COORD_W-1:0] dx,
                                     input logic [COORD_W-1:0] dy);
    return (dx >= m_dst_w) || (dy >= m_dst_h);
  endfunction

  function automatic bit fetch_is_legal(input logic [COORD_W-1:0] dx,
                                        input logic [COORD_W-1:0] dy);
    return outside_dst(dx, dy) || px_written[source_addr(dx, dy)];
  endfunction

  task automatic reset_model();
    m_channels = CH_RGB;
    m_src_w    = SIZE_RST;
    m_src_h    = SIZE_RST;
    m_dst_w    = SIZE_RST;
    m_dst_h    = SIZE_RST;
    m_x_step   = STEP_RST;
    m_y_step   = STEP_RST;
    wr_ptr     = 0;
  endtask

  // frame store update on a store, expected pixel on a fetch
  task automatic resize_lookup(input px_item_t it);
    px_result_t r;
    if (it.func == FUNC_STORE) begin
      n_stores++;
      if (it.frame_start) wr_ptr = 0;
      if (wr_ptr < frame_bound()) begin
        frame_px[wr_ptr]   = it.ch;
        px_written[wr_ptr] = 1'b1;
        wr_ptr++;
      end
    end else begin
      n_fetches++;
      r = '0;
      if (outside_dst(it.dst_x, it.dst_y)) begin
        r.range_error = 1'b1;
        n_range_err++;
      end else begin
        r.ch = frame_px[source_addr(it.dst_x, it.dst_y)];
        if (m_channels != CH_RGBA) r.ch[3] = '0;
      end
      expected_px.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
               cycle_cnt, what, want, got);
  endtask

  task automatic send_item(input px_item_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= it.func;
    in_if.frame_start <= it.frame_start;
    in_if.dst_x       <= it.dst_x;
    in_if.dst_y       <= it.dst_y;
    in_if.in_ch0      <= it.ch[0];
    in_if.in_ch1      <= it.ch[1];
    in_if.in_ch2      <= it.ch[2];
    in_if.in_ch3      <= it.ch[3];
    do @(posedge clk); while (in_if.ready !== 1'b1);
    resize_lookup(it);
    n_items++;
  endtask

  // stores cause no result, so give the pipeline time to empty as well
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: m_channels = val[CNT_W-1:0];
      REG_SRC_WIDTH:     m_src_w    = val[SZ_W-1:0];
      REG_SRC_HEIGHT:    m_src_h    = val[SZ_W-1:0];
      REG_DST_WIDTH:     m_dst_w    = val[SZ_W-1:0];
      REG_DST_HEIGHT:    m_dst_h    = val[SZ_W-1:0];
      REG_X_STEP:        m_x_step   = val[STEP_W-1:0];
      REG_Y_STEP:        m_y_step   = val[STEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CNT_W-1:0] chans,
                            input logic [SZ_W-1:0] sw, input logic [SZ_W-1:0] sh,
                            input logic [SZ_W-1:0] dw, input logic [SZ_W-1:0] dh,
                            input logic [STEP_W-1:0] xs, input logic [STEP_W-1:0] ys);
    write_reg(REG_CHANNEL_COUNT, chans);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    n_settings++;
  endtask

  function automatic px_item_t random_store();
    px_item_t it;
    it.func        = FUNC_STORE;
    it.frame_start = ($urandom_range(0, 9) == 0);
    it.dst_x       = $urandom;
    it.dst_y       = $urandom;
    it.ch          = $urandom;
    return it;
  endfunction

  function automatic px_item_t mk_store(input logic fs, input logic [PIX_W-1:0] word);
    px_item_t it;
    it             = random_store();
    it.frame_start = fs;
    it.ch          = word;
    return it;
  endfunction

  // ignored store fields carry noise on every fetch
  function automatic px_item_t mk_fetch(input logic [COORD_W-1:0] dx,
                                        input logic [COORD_W-1:0] dy);
    px_item_t it;
    it             = random_store();
    it.func        = FUNC_FETCH;
    it.frame_start = $urandom_range(0, 1);
    it.dst_x       = dx;
    it.dst_y       = dy;
    return it;
  endfunction

  // only addresses already written may be read back
  function automatic px_item_t random_fetch();
    px_item_t it;
    int       hx, hy;
    hx = (m_dst_w == 0 || m_dst_w >= 256) ? 255 : m_dst_w - 1;
    hy = (m_dst_h == 0 || m_dst_h >= 256) ? 255 : m_dst_h - 1;
    it = mk_fetch(8'd0, 8'd0);
    for (int k = 0; k < 16; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        it.dst_x = $urandom;
        it.dst_y = $urandom;
      end else begin
        it.dst_x = $urandom_range(0, hx);
        it.dst_y = $urandom_range(0, hy);
      end
      if (fetch_is_legal(it.dst_x, it.dst_y)) return it;
    end
    if (m_dst_w < 256) it.dst_x = 8'hFF;
    else if (m_dst_h < 256) it.dst_y = 8'hFF;
    else if (fetch_is_legal(8'd0, 8'd0)) it.dst_x = 8'd0;
    else it = random_store();
    if (it.func == FUNC_FETCH && !fetch_is_legal(it.dst_x, it.dst_y)) begin
      it.dst_x = 8'd0;
      it.dst_y = 8'd0;
    end
    return it;
  endfunction

  task automatic fill_frame(input int unsigned count);
    px_item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      it             = random_store();
      it.frame_start = (i == 0);
      send_item(it);
    end
  endtask

  function automatic logic [SZ_W-1:0] pick_size();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 256;
      3:       return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 25'h100_0000;
      2:       return 25'h1FF_FFFF;
      3:       return $urandom_range(0, 600);
      default: return $urandom;
    endcase
  endfunction

  initial begin : result_check
    px_result_t got, want;
    int         stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0 || hold_cnt != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_cnt != 0) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.ch[0]       = out_if.out_ch0;
      got.ch[1]       = out_if.out_ch1;
      got.ch[2]       = out_if.out_ch2;
      got.ch[3]       = out_if.out_ch3;
      got.range_error = out_if.range_error;
      n_results++;
      if (expected_px.size() == 0) begin
        report_mismatch("result with none outstanding", '0, got.ch);
      end else begin
        want = expected_px.pop_front();
        for (int k = 0; k < 4; k++)
          if (got.ch[k] !== want.ch[k])
            report_mismatch($sformatf("out_ch%0d", k), want.ch[k], got.ch[k]);
        if (got.range_error !== want.range_error)
          report_mismatch("range_error", want.range_error, got.range_error);
      end
    end
  end

  // register defaults: 3 channels, 256x256, unity steps
  task automatic test_reset_defaults();
    send_item(mk_store(1'b1, 32'h0000_0000));
    send_item(mk_store(1'b0, 32'hFFFF_FFFF));
    send_item(mk_store(1'b0, 32'h5AA5_C33C));
    send_item(mk_fetch(8'd0, 8'd0));
    send_item(mk_fetch(8'd1, 8'd0));
    send_item(mk_fetch(8'd2, 8'd0));
    settle();
  endtask

  // 2x2 source up to 4x4, alpha on, frame overrun and out-of-range fetches
  task automatic test_small_frame();
    set_config(CH_RGBA, 9'd2, 9'd2, 9'd4, 9'd4, 25'd32768, 25'd32768);
    send_item(mk_store(1'b1, 32'h0102_0304));
    send_item(mk_store(1'b0, 32'hFFFF_FFFF));
    send_item(mk_store(1'b0, 32'h0000_0000));
    send_item(mk_store(1'b0, 32'h8040_2010));
    send_item(mk_store(1'b0, 32'hDEAD_BEEF));
    send_item(mk_fetch(8'd0, 8'd0));
    send_item(mk_fetch(8'd3, 8'd3));
    send_item(mk_fetch(8'd1, 8'd2));
    send_item(mk_fetch(8'd4, 8'd0));
    send_item(mk_fetch(8'd0, 8'd4));
    send_item(mk_fetch(8'hFF, 8'hFF));
    send_item(mk_store(1'b1, 32'hA5A5_5A5A));
    send_item(mk_fetch(8'd1, 8'd1));
    settle();
  endtask

  // odd channel count, zero width clamped, steps saturating, zero destination width
  task automatic test_saturation();
    set_config(3'd7, 9'd0, 9'd2, 9'd256, 9'd256, 25'h100_0000, 25'h1FF_FFFF);
    send_item(mk_store(1'b1, 32'hFF11_2233));
    send_item(mk_store(1'b0, 32'h7F80_0102));
    send_item(mk_fetch(8'hFF, 8'hFF));
    send_item(mk_fetch(8'd0, 8'd0));
    settle();
    write_reg(REG_DST_WIDTH, '0);
    send_item(mk_fetch(8'd0, 8'd0));
    send_item(mk_fetch(8'hFF, 8'd0));
    settle();
  endtask

  // receiver holds off while fetches arrive back to back
  task automatic test_backpressure();
    set_config(CH_RGBA, 9'd8, 9'd8, 9'd16, 9'd16, 25'd32768, 25'd32768);
    src_idle = 1'b0;
    fill_frame(64);
    settle();
    hold_cnt <= HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_item(random_fetch());
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned sw, sh, dw, dh, fills;
    px_item_t    it;
    while (n_items < TARGET_ITEMS) begin
      settle();
      if ($urandom_range(0, 4) == 0) begin
        set_config($urandom_range(0, 7), pick_size(), pick_size(), pick_size(),
                   pick_size(), pick_step(), pick_step());
      end else begin
        sw = $urandom_range(1, 16);
        sh = $urandom_range(1, 16);
        dw = $urandom_range(1, 24);
        dh = $urandom_range(1, 24);
        set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                     ($urandom_range(0, 1) ? CH_RGBA : CH_RGB),
                   sw, sh, dw, dh,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262144) : (sw << FRAC) / dw,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262144) : (sh << FRAC) / dh);
      end
      src_idle = ($urandom_range(0, 2) != 0);
      snk_idle = ($urandom_range(0, 2) != 0);
      fills = frame_bound();
      if (fills > 256) fills = 256;
      // a few stores past the end of small frames get dropped
      fill_frame(fills + $urandom_range(0, 3));
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 9) < 7) it = random_fetch();
        else it = random_store();
        send_item(it);
      end
    end
  endtask

  initial begin : run_tests
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_STORE;
    in_if.frame_start <= 1'b0;
    in_if.dst_x       <= '0;
    in_if.dst_y       <= '0;
    in_if.in_ch0      <= '0;
    in_if.in_ch1      <= '0;
    in_if.in_ch2      <= '0;
    in_if.in_ch3      <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_small_frame();
    test_saturation();
    test_backpressure();
    test_random_phases();
    settle();

    $display("run covered %0d items (%0d pixel stores, %0d fetches, %0d outside destination)",
             n_items, n_stores, n_fetches, n_range_err);
    $display("%0d register settings, %0d results checked, %0d mismatches",
             n_settings, n_results, n_errors);
    if (n_errors == 0 && expected_px.size() == 0) begin
      $display("nearest_neighbor_image_scaler test passed");
    end else begin
      $display("nearest_neighbor_image_scaler test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/nns_pkg.sv
hw/rtl/nns_if.sv
hw/rtl/nns_frame_mem.sv
hw/rtl/nearest_neighbor_image_scaler.sv
tb/tb_top.sv
